>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the allocator core
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is low.
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression that must never be true, off while reset is low.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> rtl/bthalloc_pkg.sv
// ---------------------------------------------------------------------------
// Block table heap allocator package
// Shared constants, the controller state type and the command/status bundles.
// ---------------------------------------------------------------------------
package bthalloc_pkg;

    localparam int unsigned BLOCK_BYTES    = 4096;
    localparam int unsigned BLOCK_SHIFT    = $clog2(BLOCK_BYTES);
    localparam int unsigned MAX_BLOCKS_DEF = 1024;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned BIU_W  = 11;

    localparam logic [ADDR_W-1:0] HEAP_START_RST    = '0;
    localparam logic [BIU_W-1:0]  BLOCKS_IN_USE_RST = 11'd1024;

    // configuration register indexes
    localparam logic CFG_HEAP_START    = 1'b0;
    localparam logic CFG_BLOCKS_IN_USE = 1'b1;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_OOM = 1'b1;

    typedef struct packed {
        logic has_next;
        logic first;
        logic taken;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic mark;
        logic free_wr;
        logic clear;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_free;
        logic need_zero;
        logic free_in_range;
        logic found;
        logic exhausted;
        logic mark_last;
        logic chain_more;
        logic clear_last;
    } dp_stat_t;

endpackage

>>> rtl/bthalloc_dp.sv
// ---------------------------------------------------------------------------
// Block table heap allocator datapath
// Block table memory, config registers, scan/mark/free pointer and result.
// ---------------------------------------------------------------------------
module bthalloc_dp #(
    parameter int unsigned MAX_BLOCKS = bthalloc_pkg::MAX_BLOCKS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  bthalloc_pkg::ctrl_cmd_t              cmd,
    output bthalloc_pkg::dp_stat_t               stat,
    input  logic                                 s_operation,
    input  logic [bthalloc_pkg::ADDR_W-1:0]      s_request_bytes,
    input  logic [bthalloc_pkg::ADDR_W-1:0]      s_release_address,
    input  logic                                 cfg_we,
    input  logic                                 cfg_addr,
    input  logic [bthalloc_pkg::ADDR_W-1:0]      cfg_wdata,
    output logic [bthalloc_pkg::ADDR_W-1:0]      m_region_address,
    output logic                                 m_status
);
    import bthalloc_pkg::*;

    localparam int unsigned IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int unsigned LEN_W  = $clog2(MAX_BLOCKS + 1);
    localparam int unsigned NEED_W = ADDR_W - BLOCK_SHIFT + 1;
    localparam int unsigned CNT_W  = (LEN_W > NEED_W) ? LEN_W : NEED_W;

    entry_t table_mem [MAX_BLOCKS];

    logic [ADDR_W-1:0] heap_start_reg;
    logic [BIU_W-1:0]  blocks_in_use_reg;

    logic              op_reg;
    logic [NEED_W-1:0] need_reg;
    logic [LEN_W-1:0]  ptr_reg;
    logic [LEN_W-1:0]  pidx_reg;
    logic              pv_reg;
    logic [LEN_W-1:0]  run_reg;
    logic [LEN_W-1:0]  first_reg;
    logic [LEN_W-1:0]  start_reg;
    logic [LEN_W-1:0]  cnt_reg;
    logic              ok_reg;
    entry_t            rdata_reg;
    logic [ADDR_W-1:0] region_reg;
    logic              status_reg;

    logic [LEN_W-1:0]  table_len;
    logic [NEED_W-1:0] req_need;
    logic [ADDR_W-1:0] rel_diff;
    logic [ADDR_W-1:0] rel_idx;
    logic [LEN_W-1:0]  run_first;
    logic              found;
    logic              ptr_in_table;
    entry_t            mark_entry;
    logic [IDX_W-1:0]  mem_idx;

    always_comb begin
        if (ADDR_W'(blocks_in_use_reg) < ADDR_W'(MAX_BLOCKS)) begin
            table_len = LEN_W'(blocks_in_use_reg);
        end else begin
            table_len = LEN_W'(MAX_BLOCKS);
        end
    end

    // round the byte count up to whole blocks
    assign req_need = NEED_W'(s_request_bytes >> BLOCK_SHIFT)
                    + NEED_W'(s_request_bytes[BLOCK_SHIFT-1:0] != '0);
    assign rel_diff = s_release_address - heap_start_reg;
    assign rel_idx  = rel_diff >> BLOCK_SHIFT;

    assign mem_idx      = ptr_reg[IDX_W-1:0];
    assign ptr_in_table = ptr_reg < table_len;
    assign run_first    = (run_reg == '0) ? pidx_reg : first_reg;
    assign found        = cmd.scan && pv_reg && !rdata_reg.taken
                       && ((CNT_W'(run_reg) + CNT_W'(1)) == CNT_W'(need_reg));

    always_comb begin
        mark_entry          = '0;
        mark_entry.taken    = 1'b1;
        mark_entry.first    = (ptr_reg == start_reg);
        mark_entry.has_next = (cnt_reg != LEN_W'(1));
    end

    always_comb begin
        stat               = '0;
        stat.is_free       = (s_operation == OP_FREE);
        stat.need_zero     = (req_need == '0);
        stat.free_in_range = (rel_idx < ADDR_W'(table_len));
        stat.found         = found;
        stat.exhausted     = !pv_reg && !ptr_in_table;
        stat.mark_last     = (cnt_reg == LEN_W'(1));
        stat.chain_more    = rdata_reg.has_next
                          && ((ADDR_W'(ptr_reg) + ADDR_W'(1)) < ADDR_W'(table_len));
        stat.clear_last    = (ptr_reg == LEN_W'(MAX_BLOCKS - 1));
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_start_reg    <= HEAP_START_RST;
            blocks_in_use_reg <= BLOCKS_IN_USE_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_HEAP_START:    heap_start_reg    <= cfg_wdata;
                CFG_BLOCKS_IN_USE: blocks_in_use_reg <= cfg_wdata[BIU_W-1:0];
                default:           heap_start_reg    <= heap_start_reg;
            endcase
        end
    end

    // shared table pointer and read pipeline valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
            pv_reg  <= 1'b0;
        end else begin
            pv_reg <= cmd.scan && !found && ptr_in_table;
            if (cmd.start) begin
                ptr_reg <= (s_operation == OP_FREE) ? LEN_W'(rel_idx) : '0;
            end else if (cmd.scan) begin
                if (found) begin
                    ptr_reg <= run_first;
                end else if (ptr_in_table) begin
                    ptr_reg <= ptr_reg + LEN_W'(1);
                end
            end else if (cmd.mark || cmd.clear || cmd.free_wr) begin
                ptr_reg <= ptr_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        pidx_reg  <= ptr_reg;
        rdata_reg <= table_mem[mem_idx];
        if (cmd.start) begin
            op_reg   <= s_operation;
            need_reg <= req_need;
            run_reg  <= '0;
            ok_reg   <= 1'b0;
        end else if (cmd.scan && pv_reg) begin
            if (rdata_reg.taken) begin
                run_reg <= '0;
            end else begin
                run_reg   <= run_reg + LEN_W'(1);
                first_reg <= run_first;
            end
            if (found) begin
                start_reg <= run_first;
                cnt_reg   <= LEN_W'(need_reg);
                ok_reg    <= 1'b1;
            end
        end else if (cmd.mark) begin
            cnt_reg <= cnt_reg - LEN_W'(1);
        end
        if (cmd.load_out) begin
            if (op_reg == OP_ALLOC && ok_reg) begin
                region_reg <= heap_start_reg + (ADDR_W'(start_reg) << BLOCK_SHIFT);
                status_reg <= STATUS_OK;
            end else begin
                region_reg <= '0;
                status_reg <= (op_reg == OP_ALLOC) ? STATUS_OOM : STATUS_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear || cmd.free_wr) begin
            table_mem[mem_idx] <= '0;
        end else if (cmd.mark) begin
            table_mem[mem_idx] <= mark_entry;
        end
    end

    assign m_region_address = region_reg;
    assign m_status         = status_reg;

endmodule

>>> rtl/bthalloc_ctrl.sv
// ---------------------------------------------------------------------------
// Block table heap allocator controller
// Sequences clear, scan, mark and chain free, and owns the output handshake.
// ---------------------------------------------------------------------------
module bthalloc_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  bthalloc_pkg::dp_stat_t  stat,
    output bthalloc_pkg::ctrl_cmd_t cmd,
    input  logic                    s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  logic                    m_ready
);
    import bthalloc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start = 1'b1;
                    if (stat.is_free) begin
                        state_next = stat.free_in_range ? ST_FREE_RD : ST_RESP;
                    end else begin
                        state_next = stat.need_zero ? ST_RESP : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.found) begin
                    state_next = ST_MARK;
                end else if (stat.exhausted) begin
                    state_next = ST_RESP;
                end
            end
            ST_MARK: begin
                cmd.mark = 1'b1;
                if (stat.mark_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_FREE_RD: begin
                state_next = ST_FREE_WR;
            end
            ST_FREE_WR: begin
                cmd.free_wr = 1'b1;
                state_next  = stat.chain_more ? ST_FREE_RD : ST_RESP;
            end
            ST_RESP: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

>>> rtl/block_table_heap_allocator_core.sv
// ---------------------------------------------------------------------------
// Block table heap allocator core
// First-fit allocator over a table of fixed-size heap blocks.
// ---------------------------------------------------------------------------
// channel   signals                                          direction
// s_        s_valid s_ready s_operation s_request_bytes      in
//           s_release_address
// m_        m_valid m_ready m_region_address m_status        out
// cfg_      cfg_we cfg_addr cfg_wdata                        in
//
// Allocate: a first-fit scan reads one entry per cycle from the block table memory port,
// over up to len = min(blocks_in_use, MAX_BLOCKS) entries.
// Free: walks the has-next chain through ST_FREE_RD and ST_FREE_WR for each block.
// Reset: a clearing pass writes every table entry; s_ready stays low.
// One item at a time; a finished result waits in the output register while
// the next item is taken.
// ---------------------------------------------------------------------------
module block_table_heap_allocator_core #(
    parameter int unsigned MAX_BLOCKS = bthalloc_pkg::MAX_BLOCKS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_operation,
    input  logic [bthalloc_pkg::ADDR_W-1:0] s_request_bytes,
    input  logic [bthalloc_pkg::ADDR_W-1:0] s_release_address,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bthalloc_pkg::ADDR_W-1:0] m_region_address,
    output logic                            m_status,
    input  logic                            cfg_we,
    input  logic                            cfg_addr,
    input  logic [bthalloc_pkg::ADDR_W-1:0] cfg_wdata
);
    import bthalloc_pkg::*;

    `include "assert_macros.svh"

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;

    bthalloc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (dp_stat),
        .cmd     (ctrl_cmd),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

    bthalloc_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (ctrl_cmd),
        .stat              (dp_stat),
        .s_operation       (s_operation),
        .s_request_bytes   (s_request_bytes),
        .s_release_address (s_release_address),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .m_region_address  (m_region_address),
        .m_status          (m_status)
    );

    `ASSERT_SYNC(a_accept_drops_ready, aclk, aresetn, s_valid && s_ready |=> !s_ready, "ready held after a transfer")
    `ASSERT_SYNC(a_one_table_writer, aclk, aresetn, $onehot0({ctrl_cmd.clear, ctrl_cmd.mark, ctrl_cmd.free_wr}), "two table write sources at once")
    `ASSERT_NEVER(a_no_accept_in_clear, aclk, aresetn, ctrl_cmd.clear && s_ready, "input ready during table clear")

endmodule
